// ===== hdl/lslf_pkg.sv =====
`default_nettype none

package lslf_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned OUT_W = 48;
  localparam int unsigned COUNT_OUT_W = 11;

  localparam logic [OUT_W-1:0] SAT_POS = 48'h7FFF_FFFF_FFFF;
  localparam logic [OUT_W-1:0] SAT_NEG = 48'h8000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_CHECK,
    ST_DIV_LOAD,
    ST_DIV,
    ST_ROUND,
    ST_INC,
    ST_SAT,
    ST_SIGN,
    ST_DONE
  } lslf_state_e;

  typedef enum logic [2:0] {
    OP_N_SXX,
    OP_SX_SX,
    OP_N_SXY,
    OP_SX_SY,
    OP_SXX_SY,
    OP_SX_SXY
  } prod_e;

  typedef enum logic [1:0] {
    FIT_OK,
    FIT_ZERO_DET,
    FIT_TOO_MANY
  } fit_status_e;

endpackage

`default_nettype wire

// ===== hdl/least_squares_line_fit.sv =====
// Straight-line least-squares fit over a set of signed 16-bit (x, y) samples.
// A request is taken on a rising edge where start is high and busy is low; it
// carries x_value_i, y_value_i and last_point_i. A sample without the last flag
// is added to the running sums in that same cycle and busy stays low, so one
// sample per cycle is taken. The request marked last is included and then
// starts the fit: busy is high while a single shared adder works through six
// shift-and-add products of the normal equations and two restoring divisions,
// one bit per cycle. A set with a zero determinant or too many points finishes
// after the determinant. When a fit ends, result_valid_o is high for exactly
// one cycle with the result on the result ports, and busy falls in the cycle
// after. The receiver cannot stall and must take the result in that cycle.
// Samples beyond MAX_POINTS are dropped and reported in fit_status_o.
// Reset clears the sums, the count and the sequencer; the block is then idle.
`default_nettype none

module least_squares_line_fit #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [lslf_pkg::SAMPLE_W-1:0]    x_value_i,
  input  logic signed [lslf_pkg::SAMPLE_W-1:0]    y_value_i,
  input  logic                                    last_point_i,
  output logic                                    result_valid_o,
  output logic signed [lslf_pkg::OUT_W-1:0]       slope_o,
  output logic signed [lslf_pkg::OUT_W-1:0]       intercept_o,
  output logic [lslf_pkg::COUNT_OUT_W-1:0]        point_count_o,
  output logic [1:0]                              fit_status_o
);

  import lslf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned SXW = SAMPLE_W + CW;
  localparam int unsigned SXXW = 2 * SAMPLE_W + CW;

  logic accept, go;
  logic [CW-1:0] count;
  logic signed [SXW-1:0] sum_x, sum_y;
  logic signed [SXXW-1:0] sum_xx, sum_xy;
  logic overflow;
  fit_status_e status;
  logic [CW+COUNT_OUT_W-1:0] count_ext;

  assign accept = start && !busy;
  assign go     = accept && last_point_i;

  lslf_acc #(.MAX_POINTS(MAX_POINTS)) u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .add_i     (accept),
    .clr_i     (result_valid_o),
    .x_value_i (x_value_i),
    .y_value_i (y_value_i),
    .n_o       (count),
    .sum_x_o   (sum_x),
    .sum_y_o   (sum_y),
    .sum_xx_o  (sum_xx),
    .sum_xy_o  (sum_xy),
    .overflow_o(overflow)
  );

  lslf_solver #(
    .CW       (CW),
    .FRAC_BITS(FRAC_BITS)
  ) u_solver (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (go),
    .n_i        (count),
    .sum_x_i    (sum_x),
    .sum_y_i    (sum_y),
    .sum_xx_i   (sum_xx),
    .sum_xy_i   (sum_xy),
    .overflow_i (overflow),
    .busy_o     (busy),
    .done_o     (result_valid_o),
    .slope_o    (slope_o),
    .intercept_o(intercept_o),
    .status_o   (status)
  );

  assign count_ext     = (CW + COUNT_OUT_W)'(count);
  assign point_count_o = count_ext[COUNT_OUT_W-1:0];
  assign fit_status_o  = status;

endmodule

`default_nettype wire

// ===== hdl/lslf_alu.sv =====
`default_nettype none

module lslf_alu #(
  parameter int unsigned W = 70
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] sum_o,
  output logic         carry_o
);

  // With sub_i high, carry_o is set exactly when a_i >= b_i as unsigned values.
  assign {carry_o, sum_o} = (W+1)'(a_i) + (W+1)'(b_i ^ {W{sub_i}}) + (W+1)'(sub_i);

endmodule

`default_nettype wire

// ===== hdl/lslf_acc.sv =====
`default_nettype none

module lslf_acc #(
  parameter int unsigned MAX_POINTS = 1024,
  localparam int unsigned CW = $clog2(MAX_POINTS + 1)
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          add_i,
  input  logic                                          clr_i,
  input  logic signed [lslf_pkg::SAMPLE_W-1:0]          x_value_i,
  input  logic signed [lslf_pkg::SAMPLE_W-1:0]          y_value_i,
  output logic [CW-1:0]                                 n_o,
  output logic signed [lslf_pkg::SAMPLE_W+CW-1:0]       sum_x_o,
  output logic signed [lslf_pkg::SAMPLE_W+CW-1:0]       sum_y_o,
  output logic signed [2*lslf_pkg::SAMPLE_W+CW-1:0]     sum_xx_o,
  output logic signed [2*lslf_pkg::SAMPLE_W+CW-1:0]     sum_xy_o,
  output logic                                          overflow_o
);

  import lslf_pkg::*;

  localparam int unsigned SXW = SAMPLE_W + CW;
  localparam int unsigned SXXW = 2 * SAMPLE_W + CW;

  logic [CW-1:0] count_q;
  logic signed [SXW-1:0] sum_x_q, sum_y_q;
  logic signed [SXXW-1:0] sum_xx_q, sum_xy_q;
  logic overflow_q;
  logic signed [2*SAMPLE_W-1:0] xx, xy;

  assign xx = x_value_i * x_value_i;
  assign xy = x_value_i * y_value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      sum_x_q    <= '0;
      sum_y_q    <= '0;
      sum_xx_q   <= '0;
      sum_xy_q   <= '0;
      overflow_q <= 1'b0;
    end else if (clr_i) begin
      count_q    <= '0;
      sum_x_q    <= '0;
      sum_y_q    <= '0;
      sum_xx_q   <= '0;
      sum_xy_q   <= '0;
      overflow_q <= 1'b0;
    end else if (add_i) begin
      if (count_q < CW'(MAX_POINTS)) begin
        count_q  <= count_q + CW'(1);
        sum_x_q  <= sum_x_q + SXW'(x_value_i);
        sum_y_q  <= sum_y_q + SXW'(y_value_i);
        sum_xx_q <= sum_xx_q + SXXW'(xx);
        sum_xy_q <= sum_xy_q + SXXW'(xy);
      end else begin
        overflow_q <= 1'b1;
      end
    end
  end

  assign n_o        = count_q;
  assign sum_x_o    = sum_x_q;
  assign sum_y_o    = sum_y_q;
  assign sum_xx_o   = sum_xx_q;
  assign sum_xy_o   = sum_xy_q;
  assign overflow_o = overflow_q;

endmodule

`default_nettype wire

// ===== hdl/lslf_solver.sv =====
`default_nettype none

module lslf_solver #(
  parameter int unsigned CW = 11,
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned SXW = lslf_pkg::SAMPLE_W + CW,
  localparam int unsigned SXXW = 2 * lslf_pkg::SAMPLE_W + CW
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 go_i,
  input  logic [CW-1:0]                        n_i,
  input  logic signed [SXW-1:0]                sum_x_i,
  input  logic signed [SXW-1:0]                sum_y_i,
  input  logic signed [SXXW-1:0]               sum_xx_i,
  input  logic signed [SXXW-1:0]               sum_xy_i,
  input  logic                                 overflow_i,
  output logic                                 busy_o,
  output logic                                 done_o,
  output logic signed [lslf_pkg::OUT_W-1:0]    slope_o,
  output logic signed [lslf_pkg::OUT_W-1:0]    intercept_o,
  output lslf_pkg::fit_status_e                status_o
);

  import lslf_pkg::*;

  localparam int unsigned MW = SXW;
  localparam int unsigned AW = SXXW + SXW;
  localparam int unsigned DVW = AW + FRAC_BITS;
  localparam int unsigned CNTW = $clog2(DVW);

  lslf_state_e state_q, state_d;
  prod_e op_q, op_d;
  logic div_sel_q, div_sel_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  logic signed [AW-1:0] acc_q, acc_d, det_q, det_d, num_q, num_d;
  logic [AW-1:0] mcand_q, mcand_d;
  logic [MW-1:0] mplier_q, mplier_d;
  logic neg_q, neg_d;
  logic [DVW-1:0] dvd_q, dvd_d;
  logic [AW-1:0] rem_q, rem_d;
  logic rnd_q, rnd_d;
  logic [OUT_W-1:0] mag_q, mag_d;
  logic signed [OUT_W-1:0] slope_q, slope_d, icpt_q, icpt_d;
  fit_status_e status_q, status_d;

  logic [AW-1:0] alu_a, alu_b, alu_sum;
  logic alu_sub, alu_carry;

  logic signed [SXXW-1:0] opa;
  logic signed [SXW-1:0] opb, n_ext;
  logic opsub;
  logic [SXXW-1:0] opa_mag;
  logic [MW-1:0] opb_mag;

  logic last_step, det_bad, sat;
  logic signed [AW-1:0] div_num;
  logic [AW-1:0] rem_shift;
  logic [OUT_W-1:0] lim;

  lslf_alu #(.W(AW)) u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .sub_i  (alu_sub),
    .sum_o  (alu_sum),
    .carry_o(alu_carry)
  );

  assign n_ext     = SXW'(n_i);
  assign last_step = (cnt_q == '0);
  assign det_bad   = acc_q[AW-1] || (acc_q == '0);
  assign div_num   = div_sel_q ? acc_q : num_q;
  assign rem_shift = {rem_q[AW-2:0], dvd_q[DVW-1]};
  assign lim       = neg_q ? SAT_NEG : SAT_POS;
  assign sat       = (|dvd_q[DVW-1:OUT_W]) || (dvd_q[OUT_W-1:0] > lim);

  always_comb begin
    opa   = sum_xx_i;
    opb   = n_ext;
    opsub = 1'b0;
    case (op_q)
      OP_N_SXX: begin
        opa   = sum_xx_i;
        opb   = n_ext;
        opsub = 1'b0;
      end
      OP_SX_SX: begin
        opa   = SXXW'(sum_x_i);
        opb   = sum_x_i;
        opsub = 1'b1;
      end
      OP_N_SXY: begin
        opa   = sum_xy_i;
        opb   = n_ext;
        opsub = 1'b0;
      end
      OP_SX_SY: begin
        opa   = SXXW'(sum_x_i);
        opb   = sum_y_i;
        opsub = 1'b1;
      end
      OP_SXX_SY: begin
        opa   = sum_xx_i;
        opb   = sum_y_i;
        opsub = 1'b0;
      end
      OP_SX_SXY: begin
        opa   = sum_xy_i;
        opb   = sum_x_i;
        opsub = 1'b1;
      end
      default: begin
        opa   = sum_xx_i;
        opb   = n_ext;
        opsub = 1'b0;
      end
    endcase
  end

  assign opa_mag = opa[SXXW-1] ? SXXW'(-opa) : SXXW'(opa);
  assign opb_mag = opb[SXW-1] ? MW'(-opb) : MW'(opb);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (go_i) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: state_d = ST_MUL;
      ST_MUL: begin
        if (last_step) begin
          if (op_q == OP_SX_SX) begin
            state_d = ST_CHECK;
          end else if (op_q == OP_SX_SXY) begin
            state_d = ST_DIV_LOAD;
          end else begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_CHECK: begin
        if (overflow_i || det_bad) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_LOAD;
        end
      end
      ST_DIV_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (last_step) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: state_d = ST_INC;
      ST_INC:   state_d = ST_SAT;
      ST_SAT:   state_d = ST_SIGN;
      ST_SIGN: begin
        if (div_sel_q) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_DIV_LOAD;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_d      = op_q;
    div_sel_d = div_sel_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    det_d     = det_q;
    num_d     = num_q;
    mcand_d   = mcand_q;
    mplier_d  = mplier_q;
    neg_d     = neg_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    rnd_d     = rnd_q;
    mag_d     = mag_q;
    slope_d   = slope_q;
    icpt_d    = icpt_q;
    status_d  = status_q;
    alu_a     = acc_q;
    alu_b     = mcand_q;
    alu_sub   = neg_q;
    unique case (state_q)
      ST_IDLE: begin
        if (go_i) begin
          op_d      = OP_N_SXX;
          div_sel_d = 1'b0;
          slope_d   = '0;
          icpt_d    = '0;
          status_d  = FIT_OK;
        end
      end
      ST_LOAD: begin
        mcand_d  = AW'(opa_mag);
        mplier_d = opb_mag;
        neg_d    = opa[SXXW-1] ^ opb[SXW-1] ^ opsub;
        cnt_d    = CNTW'(MW - 1);
        if (op_q == OP_N_SXX) begin
          acc_d = '0;
        end else if (op_q == OP_N_SXY) begin
          acc_d = '0;
          det_d = acc_q;
        end else if (op_q == OP_SXX_SY) begin
          acc_d = '0;
          num_d = acc_q;
        end
      end
      ST_MUL: begin
        if (mplier_q[0]) begin
          acc_d = alu_sum;
        end
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - CNTW'(1);
        if (last_step && (op_q != OP_SX_SX) && (op_q != OP_SX_SXY)) begin
          op_d = prod_e'(op_q + 3'd1);
        end
      end
      ST_CHECK: begin
        if (overflow_i) begin
          status_d = FIT_TOO_MANY;
        end else if (det_bad) begin
          status_d = FIT_ZERO_DET;
        end else begin
          op_d = OP_N_SXY;
        end
      end
      ST_DIV_LOAD: begin
        alu_a   = '0;
        alu_b   = div_num;
        alu_sub = 1'b1;
        neg_d   = div_num[AW-1];
        dvd_d   = DVW'(div_num[AW-1] ? alu_sum : div_num) << FRAC_BITS;
        rem_d   = '0;
        cnt_d   = CNTW'(DVW - 1);
      end
      ST_DIV: begin
        alu_a   = rem_shift;
        alu_b   = det_q;
        alu_sub = 1'b1;
        rem_d   = alu_carry ? alu_sum : rem_shift;
        dvd_d   = {dvd_q[DVW-2:0], alu_carry};
        cnt_d   = cnt_q - CNTW'(1);
      end
      ST_ROUND: begin
        alu_a   = {rem_q[AW-2:0], 1'b0};
        alu_b   = det_q;
        alu_sub = 1'b1;
        rnd_d   = alu_carry;
      end
      ST_INC: begin
        dvd_d = dvd_q + DVW'(rnd_q);
      end
      ST_SAT: begin
        mag_d = sat ? lim : dvd_q[OUT_W-1:0];
      end
      ST_SIGN: begin
        alu_a   = '0;
        alu_b   = AW'(mag_q);
        alu_sub = neg_q;
        if (div_sel_q) begin
          icpt_d = alu_sum[OUT_W-1:0];
        end else begin
          slope_d   = alu_sum[OUT_W-1:0];
          div_sel_d = 1'b1;
        end
      end
      ST_DONE: begin
        status_d = status_q;
      end
      default: begin
        status_d = status_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= OP_N_SXX;
      div_sel_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      div_sel_q <= div_sel_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    det_q    <= det_d;
    num_q    <= num_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    neg_q    <= neg_d;
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    rnd_q    <= rnd_d;
    mag_q    <= mag_d;
    slope_q  <= slope_d;
    icpt_q   <= icpt_d;
    status_q <= status_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign done_o      = (state_q == ST_DONE);
  assign slope_o     = slope_q;
  assign intercept_o = icpt_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire
